/* hdl/sliding_window_median_filter_unit_assert.svh */
// Assertion macros used by the median filter checker.
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_UNIT_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_UNIT_ASSERT_SVH

// Checked only while reset is released.
`define SWMF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define SWMF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/swmf_pkg.sv */
package swmf_pkg;

    localparam int MAX_WIDTH = 15;
    localparam int MIN_WIDTH = 3;
    localparam int DATA_W    = 8;
    localparam int WID_W     = 4;
    localparam int CNT_W     = $clog2(MAX_WIDTH + 1);
    localparam int IDX_W     = $clog2(MAX_WIDTH);
    localparam int HALF_W    = $clog2(MAX_WIDTH / 2 + 1);

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              valid;
        logic              lt;
    } t_cell_link;

    typedef struct packed {
        logic              ins;
        logic              clr;
        logic [DATA_W-1:0] sample;
    } t_sort_cmd;

endpackage

/* hdl/swmf_sort_cell.sv */
module swmf_sort_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  swmf_pkg::t_sort_cmd   i_cmd,
    input  swmf_pkg::t_cell_link  i_prev,
    output swmf_pkg::t_cell_link  o_link
);

    logic [swmf_pkg::DATA_W-1:0] r_value;
    logic                        r_valid;
    logic [swmf_pkg::DATA_W-1:0] n_value;
    logic                        n_valid;
    logic                        w_eff_valid;
    logic                        w_lt;

    // empty cells count as +inf, so they always sit above the sorted values
    assign w_eff_valid = r_valid & ~i_cmd.clr;
    assign w_lt        = ~w_eff_valid | (i_cmd.sample < r_value);

    assign o_link.value = r_value;
    assign o_link.valid = w_eff_valid;
    assign o_link.lt    = w_lt;

    always_comb begin
        n_value = r_value;
        n_valid = w_eff_valid;
        if (i_cmd.ins && w_lt) begin
            if (i_prev.lt) begin
                n_value = i_prev.value;
                n_valid = i_prev.valid;
            end else begin
                n_value = i_cmd.sample;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

/* hdl/swmf_sorter.sv */
module swmf_sorter (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  swmf_pkg::t_sort_cmd         i_cmd,
    input  logic [swmf_pkg::IDX_W-1:0]  i_rank,
    output logic [swmf_pkg::DATA_W-1:0] o_value
);

    swmf_pkg::t_cell_link w_link [swmf_pkg::MAX_WIDTH+1];

    assign w_link[0] = '{value: '0, valid: 1'b0, lt: 1'b0};

    for (genvar g = 0; g < swmf_pkg::MAX_WIDTH; g++) begin : g_cell
        swmf_sort_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_cmd  (i_cmd),
            .i_prev (w_link[g]),
            .o_link (w_link[g+1])
        );
    end

    always_comb begin
        o_value = '0;
        for (int i = 0; i < swmf_pkg::MAX_WIDTH; i++) begin
            if (i_rank == swmf_pkg::IDX_W'(i)) begin
                o_value = w_link[i+1].value;
            end
        end
    end

endmodule

/* hdl/sliding_window_median_filter_unit.sv */
// One-dimensional median filter over a stream of 8-bit samples.
// Input beats on i_s_axis_*: tdata holds the sample, tlast marks the final
// sample of a stream. Output beats on o_m_axis_*: tdata holds the median of
// one stream position, tlast marks the final median of the stream.
// i_cfg_wr_en/i_cfg_wr_data set the window width (3..15, others clamped);
// write it only while the block is idle.
// A beat is taken in S_IDLE, then S_EVAL decides whether a median is due.
// For each median the samples of its window (at most the width) enter a
// chain of 15 sorting cells one per cycle in S_FEED, then in S_PICK the
// middle cell is read into the output register. The input is held until
// S_EVAL finds no further median due for the beat and returns to S_IDLE.
// While the receiver stalls the output register holds and the
// block waits before loading the next median; the next input beat is taken
// while the final median of the previous one still waits.
// Reset is synchronous and active low: it empties the window, drops pending
// positions, clears the output and sets the window width to 3.
module sliding_window_median_filter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] sample
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] median
    output logic       o_m_axis_tlast,
    input  logic       i_cfg_wr_en,
    input  logic [3:0] i_cfg_wr_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_FEED = 2'd2;
    localparam logic [1:0] S_PICK = 2'd3;

    logic [1:0]                        r_state;
    logic [swmf_pkg::WID_W-1:0]        r_width;
    logic [swmf_pkg::DATA_W-1:0]       r_win [swmf_pkg::MAX_WIDTH];
    logic [swmf_pkg::CNT_W-1:0]        r_filled;
    logic [swmf_pkg::CNT_W-1:0]        r_pend;
    logic                              r_is_last;
    logic [swmf_pkg::HALF_W-1:0]       r_half;
    logic [swmf_pkg::HALF_W-1:0]       r_ahead;
    logic [swmf_pkg::IDX_W-1:0]        r_k;
    logic [swmf_pkg::IDX_W-1:0]        r_hi;
    logic [swmf_pkg::IDX_W-1:0]        r_rank;
    logic                              r_res_last;
    logic                              r_first;
    logic                              r_out_valid;
    logic [swmf_pkg::DATA_W-1:0]       r_median;
    logic                              r_out_last;

    logic                              w_accept;
    logic                              w_out_free;
    logic [swmf_pkg::WID_W-1:0]        w_weff;
    logic [swmf_pkg::HALF_W-1:0]       w_half;
    logic [swmf_pkg::HALF_W-1:0]       w_ahead;
    logic                              w_due;
    logic [swmf_pkg::CNT_W-1:0]        w_d;
    logic [swmf_pkg::IDX_W-1:0]        w_lo;
    logic [swmf_pkg::CNT_W:0]          w_reach;
    logic [swmf_pkg::CNT_W:0]          w_top;
    logic [swmf_pkg::IDX_W-1:0]        w_hi;
    logic [swmf_pkg::CNT_W-1:0]        w_n;
    logic [swmf_pkg::DATA_W-1:0]       w_sorted;
    swmf_pkg::t_sort_cmd               w_cmd;

    assign w_accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_median;
    assign o_m_axis_tlast  = r_out_last;

    always_comb begin
        if (r_width < swmf_pkg::WID_W'(swmf_pkg::MIN_WIDTH)) begin
            w_weff = swmf_pkg::WID_W'(swmf_pkg::MIN_WIDTH);
        end else if (r_width > swmf_pkg::WID_W'(swmf_pkg::MAX_WIDTH)) begin
            w_weff = swmf_pkg::WID_W'(swmf_pkg::MAX_WIDTH);
        end else begin
            w_weff = r_width;
        end
        w_half  = swmf_pkg::HALF_W'(w_weff >> 1);
        w_ahead = swmf_pkg::HALF_W'(w_weff - swmf_pkg::WID_W'(1) - swmf_pkg::WID_W'(w_half));
    end

    // window bounds of the oldest pending position
    always_comb begin
        w_due   = r_is_last ? (r_pend != '0)
                            : (r_pend > swmf_pkg::CNT_W'(r_ahead));
        w_d     = r_pend - swmf_pkg::CNT_W'(1);
        w_lo    = (w_d > swmf_pkg::CNT_W'(r_ahead))
                ? swmf_pkg::IDX_W'(w_d - swmf_pkg::CNT_W'(r_ahead)) : '0;
        w_reach = {1'b0, w_d} + (swmf_pkg::CNT_W+1)'(r_half);
        w_top   = {1'b0, r_filled - swmf_pkg::CNT_W'(1)};
        w_hi    = (w_reach < w_top) ? swmf_pkg::IDX_W'(w_reach) : swmf_pkg::IDX_W'(w_top);
        w_n     = swmf_pkg::CNT_W'(w_hi - w_lo) + swmf_pkg::CNT_W'(1);
    end

    assign w_cmd.ins    = (r_state == S_FEED);
    assign w_cmd.clr    = r_first;
    assign w_cmd.sample = r_win[r_k];

    swmf_sorter u_sorter (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (w_cmd),
        .i_rank (r_rank),
        .o_value(w_sorted)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= swmf_pkg::WID_W'(swmf_pkg::MIN_WIDTH);
        end else if (i_cfg_wr_en) begin
            r_width <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_filled    <= '0;
            r_pend      <= '0;
            r_is_last   <= 1'b0;
            r_first     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_PICK && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (r_filled < swmf_pkg::CNT_W'(swmf_pkg::MAX_WIDTH)) begin
                            r_filled <= r_filled + swmf_pkg::CNT_W'(1);
                        end
                        if (r_pend < swmf_pkg::CNT_W'(swmf_pkg::MAX_WIDTH)) begin
                            r_pend <= r_pend + swmf_pkg::CNT_W'(1);
                        end
                        r_is_last <= i_s_axis_tlast;
                        r_state   <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (w_due) begin
                        r_pend  <= w_d;
                        r_first <= 1'b1;
                        r_state <= S_FEED;
                    end else begin
                        if (r_is_last) begin
                            r_filled <= '0;
                            r_pend   <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                S_FEED: begin
                    r_first <= 1'b0;
                    if (r_k == r_hi) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (w_out_free) begin
                        r_state <= S_EVAL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_win[0] <= i_s_axis_tdata;
            for (int i = 1; i < swmf_pkg::MAX_WIDTH; i++) begin
                r_win[i] <= r_win[i-1];
            end
            r_half  <= w_half;
            r_ahead <= w_ahead;
        end
        if (r_state == S_EVAL) begin
            r_k        <= w_lo;
            r_hi       <= w_hi;
            r_rank     <= swmf_pkg::IDX_W'(w_n >> 1);
            r_res_last <= r_is_last && (w_d == '0);
        end else if (r_state == S_FEED) begin
            r_k <= r_k + swmf_pkg::IDX_W'(1);
        end
        if (r_state == S_PICK && w_out_free) begin
            r_median   <= w_sorted;
            r_out_last <= r_res_last;
        end
    end

endmodule

/* hdl/swmf_checker.sv */
`include "sliding_window_median_filter_unit_assert.svh"

module swmf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_axis_tvalid,
    input logic       o_s_axis_tready,
    input logic [7:0] i_s_axis_tdata,
    input logic       i_s_axis_tlast,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic       o_m_axis_tlast,
    input logic       i_cfg_wr_en,
    input logic [3:0] i_cfg_wr_data
);

    `SWMF_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_axis_tvalid && o_s_axis_tready, "outputs not cleared by reset")

    `SWMF_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast), "stalled output beat changed")

    `SWMF_ASSERT(a_busy_after_beat, i_clk, i_rst_n, i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready, "input taken again before the previous beat was evaluated")

endmodule

bind sliding_window_median_filter_unit swmf_checker u_swmf_checker (.*);

/* tb/tb.sv */
module tb;

    typedef struct {
        logic [swmf_pkg::DATA_W-1:0] median;
        logic                        last;
    } t_filt_result;

    localparam int IDLE_GAP = 12;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        s_valid = 1'b0;
    logic [swmf_pkg::DATA_W-1:0] s_data = '0;
    logic                        s_last = 1'b0;
    logic                        m_ready = 1'b0;
    logic                        cfg_en = 1'b0;
    logic [swmf_pkg::WID_W-1:0]  cfg_data = '0;
    logic                        o_s_axis_tready;
    logic                        o_m_axis_tvalid;
    logic [swmf_pkg::DATA_W-1:0] o_m_axis_tdata;
    logic                        o_m_axis_tlast;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_cycles = 0;
    int err_count = 0;

    // filter state mirrored by the predictor
    logic [swmf_pkg::DATA_W-1:0] win [swmf_pkg::MAX_WIDTH];
    int                          fill_cnt = 0;
    int                          pend_cnt = 0;
    logic [swmf_pkg::WID_W-1:0]  width_reg = 4'd3;
    t_filt_result                median_q [$];

    sliding_window_median_filter_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),    // [7:0] sample
        .i_s_axis_tlast  (s_last),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),    // [7:0] median
        .o_m_axis_tlast  (o_m_axis_tlast),
        .i_cfg_wr_en     (cfg_en),
        .i_cfg_wr_data   (cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic [swmf_pkg::DATA_W-1:0] window_median(int d, int half, int ahead);
        logic [swmf_pkg::DATA_W-1:0] sorted [swmf_pkg::MAX_WIDTH];
        logic [swmf_pkg::DATA_W-1:0] v;
        int lo, hi, n, j, k;
        lo = (d > ahead) ? d - ahead : 0;
        hi = d + half;
        if (hi > fill_cnt - 1) hi = fill_cnt - 1;
        if (hi > swmf_pkg::MAX_WIDTH - 1) hi = swmf_pkg::MAX_WIDTH - 1;
        n = 0;
        for (k = lo; k <= hi; k++) begin
            v = win[k];
            j = n;
            while (j > 0 && sorted[j-1] > v) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = v;
            n++;
        end
        if (n == 0) return '0;
        return sorted[n/2];
    endfunction

    function automatic void predict_medians(logic [swmf_pkg::DATA_W-1:0] smp, logic lst);
        int w, half, ahead, d, k;
        t_filt_result r;
        w = int'(width_reg);
        if (w < swmf_pkg::MIN_WIDTH) w = swmf_pkg::MIN_WIDTH;
        if (w > swmf_pkg::MAX_WIDTH) w = swmf_pkg::MAX_WIDTH;
        half = w / 2;
        ahead = w - 1 - half;
        for (k = swmf_pkg::MAX_WIDTH - 1; k > 0; k--) win[k] = win[k-1];
        win[0] = smp;
        if (fill_cnt < swmf_pkg::MAX_WIDTH) fill_cnt++;
        if (pend_cnt < swmf_pkg::MAX_WIDTH) pend_cnt++;
        // last sample flushes every pending position
        while (pend_cnt > (lst ? 0 : ahead)) begin
            d = pend_cnt - 1;
            r.median = window_median(d, half, ahead);
            r.last = lst && (d == 0);
            median_q.push_back(r);
            pend_cnt--;
        end
        if (lst) begin
            fill_cnt = 0;
            pend_cnt = 0;
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %s: got %0d expected %0d at %0t", what, got, want, $time);
        err_count++;
    endtask

    task automatic send_beat(input logic [swmf_pkg::DATA_W-1:0] smp, input logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data <= smp;
        s_last <= lst;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_medians(smp, lst);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (median_q.size() != 0) @(posedge i_clk);
        repeat (IDLE_GAP) @(posedge i_clk);
    endtask

    task automatic set_width(input logic [swmf_pkg::WID_W-1:0] v);
        wait_idle();
        cfg_en <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        cfg_en <= 1'b0;
        width_reg = v;
    endtask

    // one-sample, two-sample and short streams at the reset width
    task automatic test_stream_edges();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_beat(8'hFF, 1'b1);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b1);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'h80, 1'b0);
        send_beat(8'h01, 1'b1);
    endtask

    // width 0 acts as 3; width 15 is cut short at both stream edges
    task automatic test_width_clamp();
        set_width(4'd0);
        send_beat(8'd10, 1'b0);
        send_beat(8'd200, 1'b0);
        send_beat(8'd30, 1'b1);
        set_width(4'd15);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b1);
    endtask

    // shrink mid-stream: one beat releases a backlog of medians
    task automatic test_width_shrink();
        int k;
        set_width(4'd15);
        for (k = 0; k < 8; k++) send_beat(8'($urandom), 1'b0);
        set_width(4'd2);
        send_beat(8'($urandom), 1'b0);
        send_beat(8'($urandom), 1'b1);
    endtask

    task automatic test_random_streams(input int n_items, input int idle_pct,
                                       input int stall_pct);
        int sent, len, k, cut;
        logic [swmf_pkg::DATA_W-1:0] smp;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(3) == 0) set_width(4'($urandom_range(15)));
            case ($urandom_range(9))
                0: len = $urandom_range(2, 1);
                9: len = $urandom_range(40, 25);
                default: len = $urandom_range(20, 3);
            endcase
            cut = ($urandom_range(7) == 0) ? $urandom_range(len - 1) : 0;
            for (k = 0; k < len; k++) begin
                if (cut > 0 && k == cut) set_width(4'($urandom_range(15)));
                case ($urandom_range(7))
                    0: smp = 8'($urandom_range(130, 126));
                    1: smp = ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
                    default: smp = 8'($urandom);
                endcase
                send_beat(smp, k == len - 1);
            end
            sent += len;
        end
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_output_hold();
        int k;
        set_width(4'd7);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 300;
        for (k = 0; k < 40; k++) send_beat(8'($urandom), k == 39);
    endtask

    initial begin : recv_ready
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin : check_medians
        t_filt_result want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            if (median_q.size() == 0) begin
                report_mismatch("unexpected median beat", o_m_axis_tdata, -1);
            end else begin
                want = median_q.pop_front();
                if (o_m_axis_tdata !== want.median)
                    report_mismatch("median", o_m_axis_tdata, want.median);
                if (o_m_axis_tlast !== want.last)
                    report_mismatch("tlast", o_m_axis_tlast, want.last);
            end
        end
    end

    initial begin
        #1600000;
        $display("FAIL sliding_window_median_filter_unit");
        $finish;
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_stream_edges();
        test_width_clamp();
        test_width_shrink();
        test_random_streams(85, 0, 0);
        test_random_streams(80, 63, 0);
        test_random_streams(80, 0, 63);
        test_random_streams(55, 6, 6);
        test_output_hold();
        s_valid <= 1'b0;
        while (median_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (err_count == 0)
            $display("PASS sliding_window_median_filter_unit");
        else
            $display("FAIL sliding_window_median_filter_unit");
        $finish;
    end

endmodule
